FILE: src/xbgcd_pkg.sv
`default_nettype none

package xbgcd_pkg;

    localparam int unsigned WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIP,
        S_LOOP,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_HALVE,
        OP_DIV,
        OP_SUB,
        OP_SWAPSUB
    } t_op;

    typedef struct packed {
        t_op op;
    } t_unit_ctl;

    typedef struct packed {
        logic v_zero;
        logic v_even;
        logic u_even;
        logic u_lt_v;
        logic u_gt_v;
    } t_unit_stat;

endpackage

`default_nettype wire

FILE: src/extended_binary_gcd_top.sv
// Channel   Direction  Handshake               Word
// command   in         start high, busy low    i_x, i_y
// result    out        o_done strobe, 1 cycle  o_g, o_coef_x, o_coef_y, o_undefined
//
// A word with a zero operand gives its strobe in the cycle after it is taken. Otherwise busy
// covers stripping the common factors of two, each halving, swap or subtract step, a long
// division whenever the working u is even and below an odd v, and the steps to load, detect
// the end and finish; the strobe follows. Reset is synchronous and active low and returns
// the sequencer to idle; the receiver cannot stall the result strobe.
`default_nettype none

module extended_binary_gcd_top
    import xbgcd_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [WIDTH-1:0] i_x,
    input  wire logic signed [WIDTH-1:0] i_y,
    output logic                         o_done,
    output logic [WIDTH-1:0]             o_g,
    output logic signed [WIDTH+1:0]      o_coef_x,
    output logic signed [WIDTH+1:0]      o_coef_y,
    output logic                         o_undefined
);

    localparam int unsigned CW = WIDTH + 2;
    localparam int unsigned IW = WIDTH + 3;
    localparam int unsigned KW = $clog2(WIDTH);
    localparam logic [KW-1:0] K_TOP = KW'(WIDTH - 1);

    t_state r_state;
    t_state n_state;

    logic [WIDTH-1:0]     r_x;
    logic [WIDTH-1:0]     r_y;
    logic                 r_nx;
    logic                 r_ny;
    logic [KW-1:0]        r_shift;
    logic [KW-1:0]        r_k;
    logic [WIDTH-1:0]     r_u;
    logic [WIDTH-1:0]     r_v;
    logic signed [IW-1:0] r_a;
    logic signed [IW-1:0] r_b;
    logic signed [IW-1:0] r_c;
    logic signed [IW-1:0] r_d;

    logic                 r_done;
    logic [WIDTH-1:0]     r_g;
    logic signed [CW-1:0] r_coef_x;
    logic signed [CW-1:0] r_coef_y;
    logic                 r_undefined;

    logic [WIDTH-1:0]     mag_x;
    logic [WIDTH-1:0]     mag_y;
    logic                 take;
    logic                 x_zero;
    logic                 y_zero;
    logic                 step_en;
    logic                 div_load;
    t_unit_ctl            unit_ctl;
    t_unit_stat           unit_stat;
    logic [WIDTH-1:0]     s_u;
    logic [WIDTH-1:0]     s_v;
    logic signed [IW-1:0] s_a;
    logic signed [IW-1:0] s_b;
    logic signed [IW-1:0] s_c;
    logic signed [IW-1:0] s_d;
    logic signed [IW-1:0] neg_a;
    logic signed [IW-1:0] neg_b;

    assign mag_x  = i_x[WIDTH-1] ? (WIDTH'(0) - i_x) : i_x;
    assign mag_y  = i_y[WIDTH-1] ? (WIDTH'(0) - i_y) : i_y;
    assign x_zero = (i_x == '0);
    assign y_zero = (i_y == '0);
    assign take   = start & ~busy;
    assign busy   = (r_state != S_IDLE);
    assign neg_a  = IW'(0) - r_a;
    assign neg_b  = IW'(0) - r_b;

    xbgcd_unit #(
        .WIDTH(WIDTH)
    ) u_unit (
        .i_ctl (unit_ctl),
        .i_x   (r_x),
        .i_y   (r_y),
        .i_k   (r_k),
        .i_u   (r_u),
        .i_v   (r_v),
        .i_a   (r_a),
        .i_b   (r_b),
        .i_c   (r_c),
        .i_d   (r_d),
        .o_stat(unit_stat),
        .o_u   (s_u),
        .o_v   (s_v),
        .o_a   (s_a),
        .o_b   (s_b),
        .o_c   (s_c),
        .o_d   (s_d)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && !x_zero && !y_zero) begin
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (r_x[0] | r_y[0]) begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (unit_stat.v_zero) begin
                    n_state = S_DONE;
                end else if (!unit_stat.v_even && unit_stat.u_even && unit_stat.u_lt_v) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_k == '0) begin
                    n_state = S_LOOP;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        unit_ctl.op = OP_HOLD;
        step_en     = 1'b0;
        div_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_STRIP: begin
            end
            S_LOOP: begin
                if (unit_stat.v_zero) begin
                    unit_ctl.op = OP_HOLD;
                end else if (unit_stat.v_even) begin
                    unit_ctl.op = OP_HALVE;
                    step_en     = 1'b1;
                end else if (unit_stat.u_even && unit_stat.u_lt_v) begin
                    div_load = 1'b1;
                end else if (unit_stat.u_gt_v) begin
                    unit_ctl.op = OP_SWAPSUB;
                    step_en     = 1'b1;
                end else begin
                    unit_ctl.op = OP_SUB;
                    step_en     = 1'b1;
                end
            end
            S_DIV: begin
                unit_ctl.op = OP_DIV;
                step_en     = 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (take && (x_zero || y_zero)) || (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x     <= mag_x;
            r_y     <= mag_y;
            r_nx    <= i_x[WIDTH-1];
            r_ny    <= i_y[WIDTH-1];
            r_shift <= '0;
        end
        if (r_state == S_STRIP) begin
            if (!(r_x[0] | r_y[0])) begin
                r_x     <= r_x >> 1;
                r_y     <= r_y >> 1;
                r_shift <= r_shift + KW'(1);
            end else begin
                r_u <= r_x;
                r_v <= r_y;
                r_a <= IW'(1);
                r_b <= '0;
                r_c <= '0;
                r_d <= IW'(1);
            end
        end
        if (step_en) begin
            r_u <= s_u;
            r_v <= s_v;
            r_a <= s_a;
            r_b <= s_b;
            r_c <= s_c;
            r_d <= s_d;
        end
        if (div_load) begin
            r_k <= K_TOP;
        end else if (r_state == S_DIV) begin
            r_k <= r_k - KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (x_zero && y_zero) begin
                r_g         <= '0;
                r_coef_x    <= '0;
                r_coef_y    <= '0;
                r_undefined <= 1'b1;
            end else if (x_zero) begin
                r_g         <= mag_y;
                r_coef_x    <= '0;
                r_coef_y    <= {{(CW-1){i_y[WIDTH-1]}}, 1'b1};
                r_undefined <= 1'b0;
            end else if (y_zero) begin
                r_g         <= mag_x;
                r_coef_x    <= {{(CW-1){i_x[WIDTH-1]}}, 1'b1};
                r_coef_y    <= '0;
                r_undefined <= 1'b0;
            end
        end else if (r_state == S_DONE) begin
            r_g         <= r_u << r_shift;
            r_coef_x    <= r_nx ? neg_a[CW-1:0] : r_a[CW-1:0];
            r_coef_y    <= r_ny ? neg_b[CW-1:0] : r_b[CW-1:0];
            r_undefined <= 1'b0;
        end
    end

    assign o_done      = r_done;
    assign o_g         = r_g;
    assign o_coef_x    = r_coef_x;
    assign o_coef_y    = r_coef_y;
    assign o_undefined = r_undefined;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !(take && (x_zero || y_zero))) |=> !o_done)
        else $error("result strobe lasted more than one cycle for one word");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_undefined) |-> (o_g == '0 && o_coef_x == '0 && o_coef_y == '0))
        else $error("undefined result carries nonzero data");

    a_zero_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (x_zero || y_zero)) |=> (o_done && !busy))
        else $error("zero operand did not finish in one cycle");

    a_u_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP || r_state == S_DIV) |-> (r_u != '0))
        else $error("working operand became zero");

endmodule

`default_nettype wire

FILE: src/xbgcd_unit.sv
`default_nettype none

module xbgcd_unit
    import xbgcd_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  wire t_unit_ctl                    i_ctl,
    input  wire logic [WIDTH-1:0]             i_x,
    input  wire logic [WIDTH-1:0]             i_y,
    input  wire logic [$clog2(WIDTH)-1:0]     i_k,
    input  wire logic [WIDTH-1:0]             i_u,
    input  wire logic [WIDTH-1:0]             i_v,
    input  wire logic signed [WIDTH+2:0]      i_a,
    input  wire logic signed [WIDTH+2:0]      i_b,
    input  wire logic signed [WIDTH+2:0]      i_c,
    input  wire logic signed [WIDTH+2:0]      i_d,
    output t_unit_stat                        o_stat,
    output logic [WIDTH-1:0]                  o_u,
    output logic [WIDTH-1:0]                  o_v,
    output logic signed [WIDTH+2:0]           o_a,
    output logic signed [WIDTH+2:0]           o_b,
    output logic signed [WIDTH+2:0]           o_c,
    output logic signed [WIDTH+2:0]           o_d
);

    localparam int unsigned IW = WIDTH + 3;

    logic signed [IW-1:0] x_ext;
    logic signed [IW-1:0] y_ext;
    logic signed [IW-1:0] c_adj;
    logic signed [IW-1:0] d_adj;
    logic [WIDTH-1:0]     v_hi;
    logic                 div_take;

    assign x_ext = signed'({3'b000, i_x});
    assign y_ext = signed'({3'b000, i_y});
    assign v_hi  = i_v >> i_k;
    assign div_take = (v_hi >= i_u);

    always_comb begin
        o_stat.v_zero = (i_v == '0);
        o_stat.v_even = ~i_v[0];
        o_stat.u_even = ~i_u[0];
        o_stat.u_lt_v = (i_u < i_v);
        o_stat.u_gt_v = (i_u > i_v);
    end

    always_comb begin
        if (i_c[0] | i_d[0]) begin
            c_adj = i_c + y_ext;
            d_adj = i_d - x_ext;
        end else begin
            c_adj = i_c;
            d_adj = i_d;
        end
    end

    always_comb begin
        o_u = i_u;
        o_v = i_v;
        o_a = i_a;
        o_b = i_b;
        o_c = i_c;
        o_d = i_d;
        unique case (i_ctl.op)
            OP_HOLD: begin
            end
            OP_HALVE: begin
                o_v = i_v >> 1;
                o_c = c_adj >>> 1;
                o_d = d_adj >>> 1;
            end
            OP_DIV: begin
                if (div_take) begin
                    o_v = i_v - (i_u << i_k);
                    o_c = i_c - (i_a <<< i_k);
                    o_d = i_d - (i_b <<< i_k);
                end
            end
            OP_SUB: begin
                o_v = i_v - i_u;
                o_c = i_c - i_a;
                o_d = i_d - i_b;
            end
            OP_SWAPSUB: begin
                o_u = i_v;
                o_v = i_u - i_v;
                o_a = i_c;
                o_b = i_d;
                o_c = i_a - i_c;
                o_d = i_b - i_d;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
